// ----- rtl/core/csp_pkg.sv -----
// csp_pkg: shared types, operation codes and sizes for the compacting slot pool.
// No dependencies; imported by csp_front, csp_back and the top level.
`timescale 1ns / 1ps
package csp_pkg;

  localparam int unsigned CapacityDef   = 1024;
  localparam int unsigned ValueWidthDef = 32;

  // field widths fixed by the interface
  localparam int unsigned OpW    = 3;
  localparam int unsigned SlotW  = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned WordW  = 32;
  localparam int unsigned InW    = 56;
  localparam int unsigned OutW   = 112;

  // raw operation codes on the input stream
  localparam logic [OpW-1:0] OpcSpawn   = 3'd0;
  localparam logic [OpW-1:0] OpcKillOne = 3'd1;
  localparam logic [OpW-1:0] OpcKillAll = 3'd2;
  localparam logic [OpW-1:0] OpcCompact = 3'd3;
  localparam logic [OpW-1:0] OpcRead    = 3'd4;
  localparam logic [OpW-1:0] OpcWrite   = 3'd5;

  // configuration register indexes
  localparam logic CfgCapacity = 1'b0;
  localparam logic CfgDefault  = 1'b1;

  typedef enum logic [2:0] {
    OP_SPAWN, OP_KILL_ONE, OP_KILL_ALL, OP_COMPACT, OP_READ, OP_WRITE, OP_NOP
  } op_e;

  typedef struct packed {
    op_e                kind;
    logic [SlotW-1:0]   slot;
    logic [CountW-1:0]  req;
    logic [WordW-1:0]   wval;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic [CountW-1:0]  start;
    logic [CountW-1:0]  granted;
    logic [CountW-1:0]  removed;
    logic [WordW-1:0]   id;
    logic [WordW-1:0]   value;
    logic [CountW-1:0]  live;
  } res_t;

  function automatic op_e decode_op(input logic [OpW-1:0] opc);
    op_e k;
    unique case (opc)
      OpcSpawn:   k = OP_SPAWN;
      OpcKillOne: k = OP_KILL_ONE;
      OpcKillAll: k = OP_KILL_ALL;
      OpcCompact: k = OP_COMPACT;
      OpcRead:    k = OP_READ;
      OpcWrite:   k = OP_WRITE;
      default:    k = OP_NOP;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/csp_front.sv -----
// csp_front: accepts requests, decodes the operation and holds them in a
// two-entry queue for the back end. Depends on csp_pkg.
`timescale 1ns / 1ps
module csp_front import csp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [InW-1:0]  in_data_i,
  output logic            cmd_valid_o,
  input  logic            cmd_pop_i,
  output cmd_t            cmd_o
);

  cmd_t       buf_q [2];
  logic       head_q, head_d;
  logic [1:0] fill_q, fill_d;
  cmd_t       dec;
  logic       push;
  logic       tail;

  // decode the incoming request
  always_comb begin
    dec.kind = decode_op(in_data_i[OpW-1:0]);
    dec.slot = in_data_i[OpW +: SlotW];
    dec.req  = in_data_i[OpW+SlotW +: CountW];
    dec.wval = in_data_i[OpW+SlotW+CountW +: WordW];
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = buf_q[head_q];
  assign tail        = head_q ^ fill_q[0];

  // advance pointers
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (cmd_pop_i && cmd_valid_o) begin
      head_d = ~head_q;
      fill_d = fill_d - 2'd1;
    end
    if (push) begin
      fill_d = fill_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // store the request
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[tail] <= dec;
    end
  end

endmodule

// ----- rtl/core/csp_back.sv -----
// csp_back: executes pool operations on the id, value and mark memories and
// registers one result per request. Depends on csp_pkg.
`timescale 1ns / 1ps
module csp_back import csp_pkg::*; #(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [$clog2(CAPACITY+1)-1:0]        cap_i,
  input  logic [WordW-1:0]                     default_i,
  input  logic                                 cmd_valid_i,
  output logic                                 cmd_pop_o,
  input  cmd_t                                 cmd_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output res_t                                 res_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SPAWN = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [WordW-1:0]       id_mem  [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
  logic                   mk_mem  [CAPACITY];

  logic [1:0]             state_q, state_d;
  cmd_t                   cmd_q, cmd_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          limit_q, limit_d;
  logic [WordW-1:0]       idc_q, idc_d;
  logic [CW-1:0]          i_q, i_d;
  logic [CW-1:0]          w_q, w_d;
  logic [CW-1:0]          gran_q, gran_d;
  logic                   pv_q, pv_d;
  logic [CW-1:0]          pi_q, pi_d;
  res_t                   res_q, res_d;
  logic                   rvld_q, rvld_d;

  logic [IW-1:0]          rd_addr, wr_addr;
  logic                   we_id, we_val, we_mk;
  logic [WordW-1:0]       wr_id;
  logic [VALUE_WIDTH-1:0] wr_val;
  logic                   wr_mk;
  logic [WordW-1:0]       id_rd_q;
  logic [VALUE_WIDTH-1:0] val_rd_q;
  logic                   mk_rd_q;

  logic [31:0]            slot32, cnt32, room32, gr32, req32;
  logic                   in_range, marked;
  logic [CW-1:0]          w_fin, spawn_pos;
  logic [63:0]            val64;
  res_t                   blank;

  assign slot32    = 32'(cmd_i.slot);
  assign cnt32     = 32'(count_q);
  assign req32     = 32'(cmd_i.req);
  assign room32    = (32'(cap_i) > cnt32) ? (32'(cap_i) - cnt32) : 32'd0;
  assign gr32      = (req32 < room32) ? req32 : room32;
  assign in_range  = slot32 < cnt32;
  assign marked    = mk_rd_q || (pi_q < limit_q);
  assign w_fin     = marked ? w_q : (w_q + CW'(1));
  assign spawn_pos = count_q + i_q;
  assign val64     = 64'(val_rd_q);

  always_comb begin
    blank      = '0;
    blank.live = CountW'(count_q);
  end

  // sequence operations
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    count_d   = count_q;
    limit_d   = limit_q;
    idc_d     = idc_q;
    i_d       = i_q;
    w_d       = w_q;
    gran_d    = gran_q;
    pv_d      = 1'b0;
    pi_d      = pi_q;
    res_d     = res_q;
    rvld_d    = rvld_q && !res_ready_i;
    cmd_pop_o = 1'b0;
    rd_addr   = slot32[IW-1:0];
    wr_addr   = slot32[IW-1:0];
    we_id     = 1'b0;
    we_val    = 1'b0;
    we_mk     = 1'b0;
    wr_id     = idc_q;
    wr_val    = VALUE_WIDTH'(default_i);
    wr_mk     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !rvld_q) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          res_d     = blank;
          unique case (cmd_i.kind)
            OP_SPAWN: begin
              res_d.start = CountW'(count_q);
              gran_d      = CW'(gr32);
              i_d         = '0;
              if (gr32 == 32'd0) begin
                rvld_d = 1'b1;
              end else begin
                state_d = S_SPAWN;
              end
            end
            OP_KILL_ONE: begin
              if (in_range) begin
                we_mk = 1'b1;
                wr_mk = 1'b1;
              end else begin
                res_d.status = 1'b1;
              end
              rvld_d = 1'b1;
            end
            OP_KILL_ALL: begin
              limit_d = count_q;
              rvld_d  = 1'b1;
            end
            OP_COMPACT: begin
              i_d = '0;
              w_d = '0;
              if (count_q == '0) begin
                limit_d = '0;
                rvld_d  = 1'b1;
              end else begin
                state_d = S_CMP;
              end
            end
            OP_READ: begin
              if (in_range) begin
                state_d = S_READ;
              end else begin
                res_d.status = 1'b1;
                rvld_d       = 1'b1;
              end
            end
            OP_WRITE: begin
              if (in_range) begin
                we_val = 1'b1;
                wr_val = VALUE_WIDTH'(cmd_i.wval);
              end else begin
                res_d.status = 1'b1;
              end
              rvld_d = 1'b1;
            end
            default: begin
              rvld_d = 1'b1;
            end
          endcase
        end
      end
      S_SPAWN: begin
        // fill one new slot per cycle
        wr_addr = spawn_pos[IW-1:0];
        we_id   = 1'b1;
        we_val  = 1'b1;
        we_mk   = 1'b1;
        idc_d   = idc_q + 32'd1;
        i_d     = i_q + CW'(1);
        if (i_d == gran_q) begin
          count_d       = count_q + gran_q;
          res_d.granted = CountW'(gran_q);
          res_d.live    = CountW'(count_q + gran_q);
          rvld_d        = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_CMP: begin
        // issue one read per cycle, move survivors down as data returns
        if (i_q != count_q) begin
          rd_addr = i_q[IW-1:0];
          pv_d    = 1'b1;
          pi_d    = i_q;
          i_d     = i_q + CW'(1);
        end
        if (pv_q) begin
          wr_addr = w_q[IW-1:0];
          wr_id   = id_rd_q;
          wr_val  = val_rd_q;
          if (!marked) begin
            we_id  = 1'b1;
            we_val = 1'b1;
            we_mk  = 1'b1;
          end
          w_d = w_fin;
          if (pi_q == count_q - CW'(1)) begin
            res_d.removed = CountW'(count_q - w_fin);
            res_d.live    = CountW'(w_fin);
            count_d       = w_fin;
            limit_d       = '0;
            rvld_d        = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      default: begin
        // read data is back
        res_d.id    = id_rd_q;
        res_d.value = val64[WordW-1:0];
        rvld_d      = 1'b1;
        state_d     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      limit_q <= '0;
      idc_q   <= '0;
      pv_q    <= 1'b0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      limit_q <= limit_d;
      idc_q   <= idc_d;
      pv_q    <= pv_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    i_q    <= i_d;
    w_q    <= w_d;
    gran_q <= gran_d;
    pi_q   <= pi_d;
    res_q  <= res_d;
  end

  // entry memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_id) begin
      id_mem[wr_addr] <= wr_id;
    end
    if (we_val) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (we_mk) begin
      mk_mem[wr_addr] <= wr_mk;
    end
    id_rd_q  <= id_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
    mk_rd_q  <= mk_mem[rd_addr];
  end

  assign res_valid_o = rvld_q;
  assign res_o       = res_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY) else $error("live count above capacity");
  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q <= count_q) else $error("kill-all limit above live count");
  a_cmp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (w_q <= i_q)) else $error("compact write passed read");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE && !rvld_q)) else $error("pop while busy");

endmodule

// ----- rtl/core/compacting_slot_pool_top.sv -----
// compacting_slot_pool_top: stream ports, configuration registers and the
// front/back split. Depends on csp_pkg, csp_front and csp_back.
//
// channel   dir  handshake              content
// s_axis    in   s_axis_tvalid/tready   request: operation, slot, count, value
// m_axis    out  m_axis_tvalid/tready   result: status, counts, id, value, live
// cfg       in   cfg_we_i               capacity_in_use (0), default_value (1)
//
// Read: the back end issues the read, then registers the result from the read data;
// kill one, kill all, write and other codes register their result directly.
// Spawn: one slot written per cycle. Compact: one entry read and moved per cycle.
// The queue in front is registered; the back end starts the next request once the
// result register is free. Reset clears state, live count, limit, id counter and flags.
`timescale 1ns / 1ps
module compacting_slot_pool_top import csp_pkg::*; #(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // operation[2:0], slot_index[12:3], request_count[23:13], write_value[55:24]
  input  logic [InW-1:0]    s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // status[0], start_slot[11:1], granted_count[22:12], removed_count[33:23],
  // entry_id[65:34], entry_value[97:66], live_count[108:98], zero[111:109]
  output logic [OutW-1:0]   m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [WordW-1:0]  cfg_wdata_i
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CountW-1:0] cap_q;
  logic [WordW-1:0]  dflt_q;
  logic [CW-1:0]     cap_eff;
  logic              cmd_valid, cmd_pop;
  cmd_t              cmd;
  res_t              res;

  // take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= 11'd1024;
      dflt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCapacity: cap_q  <= cfg_wdata_i[CountW-1:0];
        default:     dflt_q <= cfg_wdata_i;
      endcase
    end
  end

  // clamp capacity into one..CAPACITY
  always_comb begin
    priority if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > CAPACITY) begin
      cap_eff = CW'(CAPACITY);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  csp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  csp_back #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_eff),
    .default_i   (dflt_q),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // pack the result
  assign m_axis_tdata = {3'b000, res.live, res.value, res.id, res.removed,
                         res.granted, res.start, res.status};

endmodule
